// File: src/hba_pkg.sv
package hba_pkg;

    // fixed field widths
    localparam int DATA_BITS  = 32;
    localparam int DIFF_BITS  = DATA_BITS + 1;
    localparam int INDEX_BITS = 10;
    localparam int BINS_BITS  = 11;
    localparam int CMD_BITS   = 2;
    localparam int CFG_BITS   = 2;
    localparam int STEP_BITS  = $clog2(DATA_BITS);

    // command codes
    localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_READ   = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_BITS-1:0] CFG_MIN_VALUE   = 2'd0;
    localparam logic [CFG_BITS-1:0] CFG_BIN_SPAN    = 2'd1;
    localparam logic [CFG_BITS-1:0] CFG_BINS_IN_USE = 2'd2;

    // configuration reset values
    localparam logic [DATA_BITS-1:0] MIN_VALUE_RST   = 32'd0;
    localparam logic [DATA_BITS-1:0] BIN_SPAN_RST    = 32'd65536;
    localparam logic [BINS_BITS-1:0] BINS_IN_USE_RST = 11'd1024;

    typedef struct packed {
        logic                 start;
        logic [DATA_BITS-1:0] dividend;
        logic [DATA_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DATA_BITS-1:0] quotient;
    } div_rsp_t;

endpackage

// File: src/hba_ram.sv
module hba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/hba_div.sv
module hba_div
    import hba_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic [DATA_BITS-1:0] rem_reg;
    logic [DATA_BITS-1:0] quo_reg;
    logic [DATA_BITS-1:0] dvsr_reg;

    logic [DATA_BITS:0]   shifted;
    logic [DATA_BITS:0]   trial;
    logic                 borrow;

    // one restoring step: shift in the next dividend bit, try the subtract
    always_comb begin
        shifted         = {rem_reg, quo_reg[DATA_BITS-1]};
        {borrow, trial} = {1'b0, shifted} - {2'b00, dvsr_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && step_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            step_reg <= '1;
            rem_reg  <= '0;
            quo_reg  <= req.dividend;
            dvsr_reg <= req.divisor;
        end else if (busy_reg) begin
            step_reg <= step_reg - 1'b1;
            rem_reg  <= borrow ? shifted[DATA_BITS-1:0] : trial[DATA_BITS-1:0];
            quo_reg  <= {quo_reg[DATA_BITS-2:0], ~borrow};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// File: src/histogram_bin_accumulator_core.sv
// Fixed-width histogram engine. An insert transaction takes a signed Q16.16
// sample, forms (sample - min_value) / bin span truncated toward zero, and
// bumps that bin's count, which saturates at all ones; a quotient below zero
// or at or beyond the bins in use is flagged out_of_range and nothing is
// counted. A read returns one bin's count, a clear zeroes all bins, and every
// command returns exactly one result. An insert starts the restoring
// divider, which yields one quotient bit per cycle; the sequencer then takes
// the quotient, checks the range and reads the count, and last writes the
// count back and loads the result register. A read goes straight to the
// range check and read, a clear to the memory sweep and then a zero result,
// an unused command straight to a zero result. s_ready rises with the
// result, so a new command is taken only once the last one is done. A
// result that still waits on m_ready holds the sequencer in its last step.
// After reset the block sweeps the count memory to zero, one entry per cycle
// over all MAX_BINS entries, and holds s_ready low meanwhile; configuration
// writes are taken at any time but belong in idle periods.
module histogram_bin_accumulator_core
    import hba_pkg::*;
#(
    parameter int MAX_BINS   = 1024,
    parameter int COUNT_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // command channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CMD_BITS-1:0]   s_command,
    input  logic signed [31:0]    s_sample,
    input  logic [INDEX_BITS-1:0] s_read_bin,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [INDEX_BITS-1:0] m_bin_index,
    output logic [31:0]           m_count,
    output logic                  m_out_of_range,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_BITS-1:0]   cfg_index,
    input  logic [31:0]           cfg_data
);

    localparam int ADDR_BITS = $clog2(MAX_BINS);

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_LOOK,
        ST_RMW,
        ST_FINISH
    } state_t;

    // control state
    state_t                state_reg,   state_next;
    logic [ADDR_BITS-1:0]  clr_addr_reg, clr_addr_next;
    logic                  pend_reg,    pend_next;
    logic                  m_valid_reg, m_valid_next;

    // configuration
    logic [DATA_BITS-1:0]  min_value_reg;
    logic [DATA_BITS-1:0]  bin_span_reg;
    logic [BINS_BITS-1:0]  bins_in_use_reg;

    // per-transaction payload
    logic [CMD_BITS-1:0]   cmd_reg,     cmd_next;
    logic [DIFF_BITS-1:0]  diff_reg,    diff_next;
    logic [DATA_BITS-1:0]  bin_reg,     bin_next;
    logic                  neg_reg,     neg_next;
    logic                  oor_reg,     oor_next;

    // result register
    logic [INDEX_BITS-1:0] m_bin_index_reg,    m_bin_index_next;
    logic [31:0]           m_count_reg,        m_count_next;
    logic                  m_out_of_range_reg, m_out_of_range_next;

    // memory and divider hookup
    logic                  ram_wr_en;
    logic [ADDR_BITS-1:0]  ram_wr_addr;
    logic [COUNT_BITS-1:0] ram_wr_data;
    logic                  ram_rd_en;
    logic [COUNT_BITS-1:0] ram_rd_data;
    div_req_t              div_req;
    div_rsp_t              div_rsp;

    // helpers
    logic [DATA_BITS-1:0]  active_bins;
    logic [DIFF_BITS-1:0]  diff_neg;
    logic [COUNT_BITS-1:0] bumped;
    logic [63:0]           count_wide;
    logic                  out_free;

    // bins in use, clamped to the size of the store
    assign active_bins = (32'(bins_in_use_reg) > 32'(MAX_BINS)) ?
                         32'(MAX_BINS) : 32'(bins_in_use_reg);

    assign diff_neg = -diff_reg;
    // saturating increment of the count just read
    assign bumped   = (ram_rd_data == {COUNT_BITS{1'b1}}) ?
                      ram_rd_data : ram_rd_data + COUNT_BITS'(1);
    assign out_free = !m_valid_reg || m_ready;

    // config registers are write-only and always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_value_reg   <= MIN_VALUE_RST;
            bin_span_reg    <= BIN_SPAN_RST;
            bins_in_use_reg <= BINS_IN_USE_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MIN_VALUE:   min_value_reg   <= cfg_data;
                CFG_BIN_SPAN:    bin_span_reg    <= cfg_data;
                CFG_BINS_IN_USE: bins_in_use_reg <= cfg_data[BINS_BITS-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        state_next          = state_reg;
        clr_addr_next       = clr_addr_reg;
        pend_next           = pend_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        cmd_next            = cmd_reg;
        diff_next           = diff_reg;
        bin_next            = bin_reg;
        neg_next            = neg_reg;
        oor_next            = oor_reg;
        m_bin_index_next    = m_bin_index_reg;
        m_count_next        = m_count_reg;
        m_out_of_range_next = m_out_of_range_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = clr_addr_reg;
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        count_wide  = '0;

        div_req.start    = 1'b0;
        div_req.dividend = diff_reg[DIFF_BITS-1] ? diff_neg[DATA_BITS-1:0]
                                                 : diff_reg[DATA_BITS-1:0];
        div_req.divisor  = bin_span_reg;

        unique case (state_reg)
            // zero one memory entry per cycle
            ST_SWEEP: begin
                ram_wr_en     = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_BITS'(MAX_BINS - 1)) begin
                    clr_addr_next = '0;
                    state_next    = pend_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next  = s_command;
                    // 33-bit signed difference
                    diff_next = {s_sample[31], s_sample}
                              - {min_value_reg[DATA_BITS-1], min_value_reg};
                    bin_next  = 32'(s_read_bin);
                    neg_next  = 1'b0;
                    unique case (s_command)
                        CMD_INSERT: state_next = ST_START;
                        CMD_READ:   state_next = ST_LOOK;
                        CMD_CLEAR: begin
                            pend_next  = 1'b1;
                            state_next = ST_SWEEP;
                        end
                        default:    state_next = ST_FINISH;
                    endcase
                end
            end
            // divide the magnitude; a negative difference only fits bin 0
            ST_START: begin
                div_req.start = 1'b1;
                neg_next      = diff_reg[DIFF_BITS-1];
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    bin_next   = div_rsp.quotient;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                oor_next   = (neg_reg && bin_reg != '0) || (bin_reg >= active_bins);
                ram_rd_en  = 1'b1;
                state_next = ST_RMW;
            end
            ST_RMW: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_out_of_range_next = oor_reg;
                    m_bin_index_next    = oor_reg ? '0 : bin_reg[INDEX_BITS-1:0];
                    if (oor_reg) begin
                        count_wide = '0;
                    end else if (cmd_reg == CMD_INSERT) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = bin_reg[ADDR_BITS-1:0];
                        ram_wr_data = bumped;
                        count_wide  = 64'(bumped);
                    end else begin
                        count_wide  = 64'(ram_rd_data);
                    end
                    m_count_next = count_wide[31:0];
                    state_next   = ST_IDLE;
                end
            end
            // clear or unused command: all-zero result
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_bin_index_next    = '0;
                    m_count_next        = '0;
                    m_out_of_range_next = 1'b0;
                    pend_next           = 1'b0;
                    state_next          = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_SWEEP;
            clr_addr_reg <= '0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
        end
        cmd_reg            <= cmd_next;
        diff_reg           <= diff_next;
        bin_reg            <= bin_next;
        neg_reg            <= neg_next;
        oor_reg            <= oor_next;
        m_bin_index_reg    <= m_bin_index_next;
        m_count_reg        <= m_count_next;
        m_out_of_range_reg <= m_out_of_range_next;
    end

    hba_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    hba_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MAX_BINS)
    ) u_counts (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (bin_reg[ADDR_BITS-1:0]),
        .rd_data (ram_rd_data)
    );

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_bin_index    = m_bin_index_reg;
    assign m_count        = m_count_reg;
    assign m_out_of_range = m_out_of_range_reg;

    // an out-of-range result carries no bin and no count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_of_range |-> m_bin_index == '0 && m_count == '0)
        else $error("out-of-range result carries bin or count");

    // a count written back by an insert never wraps to zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en && state_reg == ST_RMW |-> ram_wr_data != '0)
        else $error("count wrapped on increment");

    // the divider only finishes while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == ST_DIV)
        else $error("divider finished outside its wait state");

    // the memory is never read and swept in the same cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SWEEP |-> !ram_rd_en && !s_ready)
        else $error("activity during memory sweep");

endmodule

// File: test/tb_histogram_bin_accumulator_core.sv
`timescale 1ns / 100ps

module tb_histogram_bin_accumulator_core
    import hba_pkg::*;
();

    localparam int MAX_BINS   = 1024;
    localparam int COUNT_BITS = 32;

    // command code that the block does not use, and the spare register slot
    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
    localparam logic [CFG_BITS-1:0] CFG_SPARE  = 2'd3;

    // run shape
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int DRAIN_CYCLES    = 48;
    localparam int PRINT_LIMIT     = 100;

    localparam longint SAMPLE_LO = -64'sd2147483648;
    localparam longint SAMPLE_HI = 64'sd2147483647;

    typedef struct packed {
        logic [INDEX_BITS-1:0] bin_index;
        logic [31:0]           count;
        logic                  out_of_range;
    } bin_result_t;

    // dut signals
    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [CMD_BITS-1:0]   s_command;
    logic signed [31:0]    s_sample;
    logic [INDEX_BITS-1:0] s_read_bin;
    logic                  m_valid;
    logic                  m_ready;
    logic [INDEX_BITS-1:0] m_bin_index;
    logic [31:0]           m_count;
    logic                  m_out_of_range;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_BITS-1:0]   cfg_index;
    logic [31:0]           cfg_data;

    // predictor state: per-bin counts and the register copies
    logic [COUNT_BITS-1:0] hist_counts [MAX_BINS];
    logic signed [31:0]    cur_min;
    logic [31:0]           cur_width;
    logic [BINS_BITS-1:0]  cur_bins;

    // results predicted at acceptance, oldest first
    bin_result_t expected_bin_results[$];

    int          fail_count;
    int          burst_left;
    int unsigned hot_span;

    // receiver stall pattern state
    int unsigned ready_mode;
    int unsigned mode_left;

    histogram_bin_accumulator_core #(
        .MAX_BINS   (MAX_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_sample       (s_sample),
        .s_read_bin     (s_read_bin),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_bin_index    (m_bin_index),
        .m_count        (m_count),
        .m_out_of_range (m_out_of_range),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // bins in use, clamped to the store size
    function automatic int unsigned active_bins();
        return (cur_bins > MAX_BINS) ? MAX_BINS : int'(cur_bins);
    endfunction

    // apply one accepted command to the predicted store and queue its result
    task automatic predict_bin_update(input logic [CMD_BITS-1:0] cmd,
                                      input logic signed [31:0] smp,
                                      input logic [INDEX_BITS-1:0] rbin);
        bin_result_t res;
        longint      diff;
        longint      wid;
        longint      quo;
        logic        hit;
        int unsigned active;
        res    = '0;
        active = active_bins();
        case (cmd)
            CMD_INSERT: begin
                // 33-bit difference, quotient truncated toward zero
                diff = longint'(smp) - longint'(cur_min);
                wid  = longint'(cur_width);
                hit  = 1'b0;
                quo  = 0;
                if (cur_width != '0) begin
                    if (diff < 0) begin
                        // only a difference smaller than one width lands in bin 0
                        hit = (-diff < wid);
                    end else begin
                        quo = diff / wid;
                        hit = 1'b1;
                    end
                    hit = hit && (quo < longint'(active));
                end
                if (hit) begin
                    if (hist_counts[quo] != '1) begin
                        hist_counts[quo] = hist_counts[quo] + 1'b1;
                    end
                    res.bin_index = INDEX_BITS'(quo);
                    res.count     = 32'(hist_counts[quo]);
                end else begin
                    res.out_of_range = 1'b1;
                end
            end
            CMD_READ: begin
                if (int'(rbin) < active) begin
                    res.bin_index = rbin;
                    res.count     = 32'(hist_counts[rbin]);
                end else begin
                    res.out_of_range = 1'b1;
                end
            end
            CMD_CLEAR: begin
                foreach (hist_counts[i]) hist_counts[i] = '0;
            end
            default: begin
                // unused command leaves everything alone
            end
        endcase
        expected_bin_results.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < PRINT_LIMIT) begin
            $display("mismatch %s: got 0x%08h want 0x%08h at %0t ns", what, got, want, $time);
        end
        fail_count++;
    endtask

    // send one command transaction; the sender idles between bursts
    task automatic send_command(input logic [CMD_BITS-1:0] cmd,
                                input logic signed [31:0] smp,
                                input logic [INDEX_BITS-1:0] rbin);
        if (burst_left <= 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 24);
        end
        burst_left--;
        s_valid    <= 1'b1;
        s_command  <= cmd;
        s_sample   <= smp;
        s_read_bin <= rbin;
        do @(posedge aclk); while (!s_ready);
        predict_bin_update(cmd, smp, rbin);
    endtask

    // register write; only called while nothing is in flight
    task automatic write_config(input logic [CFG_BITS-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_MIN_VALUE:   cur_min   = data;
            CFG_BIN_SPAN:    cur_width = data;
            CFG_BINS_IN_USE: cur_bins  = data[BINS_BITS-1:0];
            default: begin
                // spare slot is ignored
            end
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // hold the sender off until every predicted result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_bin_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // insert edges under the reset configuration: left edge 0, width 1.0, 1024 bins
    task automatic test_insert_edges();
        send_command(CMD_INSERT, 32'sh0000_0000, 10'h000);
        // small negative difference still lands in bin 0
        send_command(CMD_INSERT, 32'shFFFF_FFFF, 10'h3FF);
        // exactly one width below the edge is out
        send_command(CMD_INSERT, 32'shFFFF_0000, 10'h000);
        send_command(CMD_INSERT, 32'sh8000_0000, 10'h3FF);
        send_command(CMD_INSERT, 32'sh7FFF_FFFF, 10'h000);
        // top of the last bin, then one past it
        send_command(CMD_INSERT, 32'sh03FF_FFFF, 10'h155);
        send_command(CMD_INSERT, 32'sh0400_0000, 10'h2AA);
        send_command(CMD_INSERT, 32'sh0001_8000, 10'h000);
        drain_results();
    endtask

    // reads, the unused command and clear
    task automatic test_read_clear();
        send_command(CMD_READ, 32'sh7FFF_FFFF, 10'h000);
        send_command(CMD_READ, 32'sh8000_0000, 10'h3FF);
        send_command(CMD_READ, 32'sh0000_0000, 10'h200);
        send_command(CMD_UNUSED, 32'($urandom), 10'h3FF);
        send_command(CMD_CLEAR, 32'shFFFF_FFFF, 10'h3FF);
        send_command(CMD_READ, 32'sh0000_0000, 10'h000);
        send_command(CMD_INSERT, 32'sh0000_0000, 10'h000);
        drain_results();
    endtask

    // register extremes: widest width, zero width, no bins, clamped bins
    task automatic test_config_corners();
        write_config(CFG_MIN_VALUE, 32'h8000_0000);
        write_config(CFG_BIN_SPAN, 32'hFFFF_FFFF);
        // upper data bits are not part of the register
        write_config(CFG_BINS_IN_USE, 32'hFFFF_F802);
        send_command(CMD_INSERT, 32'sh7FFF_FFFF, 10'h000);
        send_command(CMD_INSERT, 32'sh8000_0000, 10'h000);
        send_command(CMD_READ, 32'sh0000_0000, 10'h002);
        drain_results();

        // zero width flags every insert
        write_config(CFG_BIN_SPAN, 32'h0000_0000);
        send_command(CMD_INSERT, 32'sh0000_0000, 10'h000);
        send_command(CMD_READ, 32'sh0000_0000, 10'h001);
        drain_results();

        // no bins in use: inserts and reads all out of range
        write_config(CFG_MIN_VALUE, 32'h7FFF_FFFF);
        write_config(CFG_BIN_SPAN, 32'h0000_0001);
        write_config(CFG_BINS_IN_USE, 32'hABCD_F800);
        send_command(CMD_INSERT, 32'sh7FFF_FFFF, 10'h000);
        send_command(CMD_READ, 32'sh0000_0000, 10'h000);
        drain_results();

        // bins beyond the store size clamp to the store size
        write_config(CFG_BINS_IN_USE, 32'h0000_07FF);
        write_config(CFG_SPARE, $urandom);
        send_command(CMD_INSERT, 32'sh7FFF_FFFF, 10'h000);
        send_command(CMD_INSERT, 32'sh7FFF_FFFE, 10'h000);
        send_command(CMD_READ, 32'sh0000_0000, 10'h3FF);
        drain_results();
    endtask

    task automatic randomize_config();
        logic [31:0] width;
        logic [31:0] left;
        logic [31:0] bins_word;
        case ($urandom_range(0, 6))
            0:       width = 32'd1;
            1:       width = $urandom_range(1, 16);
            2:       width = 32'd65536;
            3:       width = $urandom_range(1, 65535) << $urandom_range(0, 8);
            4:       width = $urandom;
            5:       width = 32'hFFFF_FFFF;
            default: width = $urandom_range(256, 1 << 20);
        endcase
        case ($urandom_range(0, 5))
            0:       left = 32'h8000_0000;
            1:       left = 32'h7FFF_FFFF;
            2, 3:    left = 32'($urandom_range(0, 2000)) - 32'd1000;
            default: left = $urandom;
        endcase
        bins_word = $urandom;
        case ($urandom_range(0, 5))
            0:       bins_word[BINS_BITS-1:0] = 11'd1;
            1:       bins_word[BINS_BITS-1:0] = 11'd2;
            2:       bins_word[BINS_BITS-1:0] = BINS_BITS'($urandom_range(3, 64));
            3:       bins_word[BINS_BITS-1:0] = 11'd1024;
            4:       bins_word[BINS_BITS-1:0] = BINS_BITS'($urandom_range(1025, 2047));
            default: bins_word[BINS_BITS-1:0] = BINS_BITS'($urandom_range(1, 1024));
        endcase
        write_config(CFG_MIN_VALUE, left);
        write_config(CFG_BIN_SPAN, width);
        write_config(CFG_BINS_IN_USE, bins_word);
    endtask

    // mostly inserts aimed at used bins, some stray samples, reads, rare clears
    task automatic random_item();
        int unsigned           pick;
        int unsigned           active;
        int unsigned           bin_sel;
        longint                diff;
        longint                target;
        logic signed [31:0]    smp;
        logic [INDEX_BITS-1:0] rbin;
        pick   = $urandom_range(0, 999);
        active = active_bins();
        smp    = $urandom;
        rbin   = INDEX_BITS'($urandom);
        if (pick < 700) begin
            if (cur_width != '0 && $urandom_range(0, 3) != 0) begin
                if ($urandom_range(0, 9) == 0) begin
                    diff = -longint'($urandom % cur_width);
                end else begin
                    // half the hits go to a few hot bins so counts climb
                    bin_sel = ($urandom_range(0, 1) == 0) ? $urandom_range(0, hot_span)
                                                          : $urandom_range(0, active + 1);
                    diff = longint'(bin_sel) * longint'(cur_width)
                         + longint'($urandom % cur_width);
                end
                target = longint'(cur_min) + diff;
                if (target >= SAMPLE_LO && target <= SAMPLE_HI) begin
                    smp = 32'(target);
                end
            end
            send_command(CMD_INSERT, smp, rbin);
        end else if (pick < 960) begin
            if ($urandom_range(0, 3) != 0) begin
                rbin = INDEX_BITS'($urandom_range(0, active + 1));
            end
            send_command(CMD_READ, smp, rbin);
        end else if (pick < 975) begin
            send_command(CMD_CLEAR, smp, rbin);
        end else begin
            send_command(CMD_UNUSED, smp, rbin);
        end
    endtask

    // each phase starts from an empty pipe with a fresh configuration
    task automatic test_random_traffic();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_results();
            randomize_config();
            hot_span = $urandom_range(0, 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                random_item();
            end
        end
        drain_results();
    endtask

    // receiver: switches between always ready, coin flip and sparse ready
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            ready_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(20, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= $urandom_range(0, 1);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // compare every accepted result transaction with the oldest prediction
    always @(posedge aclk) begin : check_results
        bin_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_bin_results.size() == 0) begin
                report_mismatch("result with nothing pending", m_count, 32'd0);
            end else begin
                want = expected_bin_results.pop_front();
                if (m_bin_index !== want.bin_index) begin
                    report_mismatch("bin_index", 32'(m_bin_index), 32'(want.bin_index));
                end
                if (m_count !== want.count) begin
                    report_mismatch("count", m_count, want.count);
                end
                if (m_out_of_range !== want.out_of_range) begin
                    report_mismatch("out_of_range", 32'(m_out_of_range),
                                    32'(want.out_of_range));
                end
            end
        end
    end

    // watchdog
    initial begin
        #7_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        aclk       = 1'b0;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_command  = CMD_INSERT;
        s_sample   = '0;
        s_read_bin = '0;
        m_ready    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_MIN_VALUE;
        cfg_data   = '0;
        fail_count = 0;
        burst_left = 0;
        hot_span   = 0;
        ready_mode = 0;
        mode_left  = 0;
        cur_min    = MIN_VALUE_RST;
        cur_width  = BIN_SPAN_RST;
        cur_bins   = BINS_IN_USE_RST;
        foreach (hist_counts[i]) hist_counts[i] = '0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_insert_edges();
        test_read_clear();
        test_config_corners();
        test_random_traffic();

        if (fail_count == 0 && expected_bin_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
